@@ hdl/ssg_pkg.sv @@
// shared types and constants for the siren sweep tone generator
// no dependencies; used by every module under hdl

package ssg_pkg;

	// default sizes, handed to the top level as parameter defaults
	localparam int SINE_TABLE_BITS_DEF  = 10;
	localparam int PHASE_BITS_DEF       = 32;
	localparam int FRAME_COUNT_BITS_DEF = 24;

	// register file layout
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int TONE_STEP_W = 31;
	localparam int LFO_STEP_W  = 24;
	localparam int AMP_W       = 15;
	localparam int FADE_W      = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LOW_FREQ_STEP  = 3'd0,
		REG_HIGH_FREQ_STEP = 3'd1,
		REG_WAIL_LFO_STEP  = 3'd2,
		REG_YELP_LFO_STEP  = 3'd3,
		REG_AMPLITUDE      = 3'd4,
		REG_FADE_LENGTH    = 3'd5
	} cfg_reg_t;

	localparam logic [TONE_STEP_W-1:0] LOW_FREQ_STEP_RST  = 31'd85704563;
	localparam logic [TONE_STEP_W-1:0] HIGH_FREQ_STEP_RST = 31'd171409126;
	localparam logic [LFO_STEP_W-1:0]  WAIL_LFO_STEP_RST  = 24'd19478;
	localparam logic [LFO_STEP_W-1:0]  YELP_LFO_STEP_RST  = 24'd292170;
	localparam logic [AMP_W-1:0]       AMPLITUDE_RST      = 15'd27853;
	localparam logic [FADE_W-1:0]      FADE_LENGTH_RST    = 16'd176;

	typedef struct packed {
		logic [TONE_STEP_W-1:0] low_freq_step;
		logic [TONE_STEP_W-1:0] high_freq_step;
		logic [LFO_STEP_W-1:0]  wail_lfo_step;
		logic [LFO_STEP_W-1:0]  yelp_lfo_step;
		logic [AMP_W-1:0]       amplitude;
		logic [FADE_W-1:0]      fade_length;
	} cfg_regs_t;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// quarter sine polynomial coefficients, q15
	localparam logic [16:0] SIN_A = 17'd51472;
	localparam logic [16:0] SIN_B = 17'd21024;
	localparam logic [16:0] SIN_C = 17'd2320;
	localparam logic [16:0] Q15_ONE = 17'd32768;
	localparam logic [16:0] Q16_ONE = 17'd65536;

	// divider: rounded scaled product over fade length, 15 quotient bits
	localparam int DIV_N_W  = 34;
	localparam int QUOT_W   = 15;
	localparam int DIV_CNT_W = 4;
	localparam logic [QUOT_W-1:0] QUOT_SAT = 15'h7fff;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LO,
		ST_HI,
		ST_PHASE,
		ST_SQ,
		ST_T,
		ST_T2,
		ST_MAG,
		ST_NUM,
		ST_AMP,
		ST_SCALE,
		ST_DIVGO,
		ST_DIV,
		ST_DONE
	} seq_state_t;

endpackage

@@ hdl/ssg_cfg.sv @@
// configuration register file with reset defaults
// depends on ssg_pkg

module ssg_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ssg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ssg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ssg_pkg::cfg_regs_t             regs
);

	ssg_pkg::cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.low_freq_step  <= ssg_pkg::LOW_FREQ_STEP_RST;
			regs_q.high_freq_step <= ssg_pkg::HIGH_FREQ_STEP_RST;
			regs_q.wail_lfo_step  <= ssg_pkg::WAIL_LFO_STEP_RST;
			regs_q.yelp_lfo_step  <= ssg_pkg::YELP_LFO_STEP_RST;
			regs_q.amplitude      <= ssg_pkg::AMPLITUDE_RST;
			regs_q.fade_length    <= ssg_pkg::FADE_LENGTH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ssg_pkg::REG_LOW_FREQ_STEP:
					regs_q.low_freq_step <= cfg_data[ssg_pkg::TONE_STEP_W-1:0];
				ssg_pkg::REG_HIGH_FREQ_STEP:
					regs_q.high_freq_step <= cfg_data[ssg_pkg::TONE_STEP_W-1:0];
				ssg_pkg::REG_WAIL_LFO_STEP:
					regs_q.wail_lfo_step <= cfg_data[ssg_pkg::LFO_STEP_W-1:0];
				ssg_pkg::REG_YELP_LFO_STEP:
					regs_q.yelp_lfo_step <= cfg_data[ssg_pkg::LFO_STEP_W-1:0];
				ssg_pkg::REG_AMPLITUDE:
					regs_q.amplitude <= cfg_data[ssg_pkg::AMP_W-1:0];
				ssg_pkg::REG_FADE_LENGTH:
					regs_q.fade_length <= cfg_data[ssg_pkg::FADE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/ssg_mul.sv @@
// shared unsigned multiplier with registered product
// depends on ssg_pkg

module ssg_mul (
	input  logic                        clk,
	input  logic [ssg_pkg::MUL_A_W-1:0] a,
	input  logic [ssg_pkg::MUL_B_W-1:0] b,
	output logic [ssg_pkg::MUL_P_W-1:0] p
);

	logic [ssg_pkg::MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= ssg_pkg::MUL_P_W'(a) * ssg_pkg::MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

@@ hdl/ssg_div.sv @@
// restoring divider, one quotient bit per cycle, saturating at 15 bits
// depends on ssg_pkg

module ssg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ssg_pkg::DIV_N_W-1:0] dividend,
	input  logic [ssg_pkg::FADE_W-1:0]  divisor,
	output ssg_pkg::div_res_t           res
);

	logic                          busy_q;
	logic                          done_q;
	logic [ssg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [ssg_pkg::FADE_W-1:0]    rem_q;
	logic [ssg_pkg::QUOT_W-1:0]    low_q;
	logic [ssg_pkg::QUOT_W-1:0]    quot_q;

	logic                       over;
	logic [ssg_pkg::FADE_W:0]   trial;
	logic                       take;
	logic [ssg_pkg::FADE_W:0]   diff;

	// quotient would not fit in 15 bits
	assign over  = dividend >= {3'b000, divisor, {ssg_pkg::QUOT_W{1'b0}}};
	assign trial = {rem_q, low_q[ssg_pkg::QUOT_W-1]};
	assign take  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= !over;
				done_q <= over;
				cnt_q  <= ssg_pkg::DIV_CNT_W'(ssg_pkg::QUOT_W);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != ssg_pkg::DIV_CNT_W'(1));
				done_q <= (cnt_q == ssg_pkg::DIV_CNT_W'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// dividend below divisor*2^15 here, so the top part fits the remainder
			rem_q  <= dividend[ssg_pkg::QUOT_W +: ssg_pkg::FADE_W];
			low_q  <= dividend[ssg_pkg::QUOT_W-1:0];
			quot_q <= over ? ssg_pkg::QUOT_SAT : '0;
		end else if (busy_q) begin
			rem_q  <= take ? diff[ssg_pkg::FADE_W-1:0] : trial[ssg_pkg::FADE_W-1:0];
			low_q  <= {low_q[ssg_pkg::QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[ssg_pkg::QUOT_W-2:0], take};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule

@@ hdl/siren_sweep_tone_generator.sv @@
// siren sweep tone generator: triangle lfo sweeping a sine nco, with fades
// each sample passes eight products through the one shared multiplier and the
// 15-step fade divider; a saturating level skips the divider steps and a silent
// sample skips the arithmetic. in_ready is high only while the sequencer is
// idle; a finished beat waits in the output register. arst_n clears phases,
// index, block state and the register file

module siren_sweep_tone_generator #(
	parameter int SINE_TABLE_BITS  = ssg_pkg::SINE_TABLE_BITS_DEF,
	parameter int PHASE_BITS       = ssg_pkg::PHASE_BITS_DEF,
	parameter int FRAME_COUNT_BITS = ssg_pkg::FRAME_COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            start_block,
	input  logic                            mode,
	input  logic [23:0]                     block_frames,
	// sample channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [15:0]              sample,
	output logic                            last_in_block,
	output logic                            active,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ssg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int PB  = PHASE_BITS;
	localparam int FCB = FRAME_COUNT_BITS;
	localparam int STB = SINE_TABLE_BITS;

	// ---------------------------------------------------------------
	// register file
	// ---------------------------------------------------------------
	ssg_pkg::cfg_regs_t regs;

	ssg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// ---------------------------------------------------------------
	// block and phase state
	// ---------------------------------------------------------------
	ssg_pkg::seq_state_t state_q, state_d;

	logic [PB-1:0]             tone_q;
	logic [PB-1:0]             lfo_q;
	logic [FCB-1:0]            idx_q;
	logic [FCB-1:0]            len_q;
	logic [ssg_pkg::FADE_W-1:0] fade_q;
	logic                      mode_q;
	logic                      open_q;
	logic                      silent_q;
	logic                      out_valid_q;

	// per-sample working registers
	logic [47:0]                low_prod_q;
	logic [16:0]                x2_q;
	logic [ssg_pkg::FADE_W-1:0] num_q;
	logic [ssg_pkg::FADE_W-1:0] den_q;
	logic [ssg_pkg::DIV_N_W-1:0] scaled_q;
	logic [15:0]                res_q;
	logic                       neg_q;

	// output register
	logic [15:0] sample_q;
	logic        last_q;
	logic        active_q;

	// ---------------------------------------------------------------
	// shared units
	// ---------------------------------------------------------------
	logic [ssg_pkg::MUL_A_W-1:0] mul_a;
	logic [ssg_pkg::MUL_B_W-1:0] mul_b;
	logic [ssg_pkg::MUL_P_W-1:0] prod;
	logic                        div_start;
	ssg_pkg::div_res_t           div_res;

	ssg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	ssg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (scaled_q),
		.divisor  (den_q),
		.res      (div_res)
	);

	// ---------------------------------------------------------------
	// block start: frame count and clamped fade length
	// ---------------------------------------------------------------
	logic                       accept;
	logic [FCB-1:0]             frames;
	logic [FCB-1:0]             half_frames;
	logic [ssg_pkg::FADE_W-1:0] fade_start;
	logic                       opens;

	assign accept      = in_valid && in_ready;
	assign frames      = FCB'(block_frames);
	assign half_frames = frames >> 1;

	always_comb begin
		fade_start = regs.fade_length;
		if (regs.fade_length != '0) begin
			if (33'(regs.fade_length) > 33'(half_frames))
				fade_start = ssg_pkg::FADE_W'(half_frames);
			if (33'(half_frames) == 33'd0 || fade_start == '0)
				fade_start = ssg_pkg::FADE_W'(1);
		end
	end

	// a start opens the block, or closes it if zero frames; else open_q carries on
	assign opens = start_block ? (frames != '0) : open_q;

	// ---------------------------------------------------------------
	// triangle from the lfo phase, q16 in 0..65536
	// ---------------------------------------------------------------
	logic [63:0] lfo_fold;
	logic [63:0] lfo_dbl;
	logic [16:0] tri_u;

	assign lfo_fold = lfo_q[PB-1] ? ((64'd1 << PB) - 64'(lfo_q)) : 64'(lfo_q);
	assign lfo_dbl  = (lfo_fold << 1) >> (PB - 16);
	assign tri_u    = lfo_dbl[16:0];

	// ---------------------------------------------------------------
	// sine table index from the tone phase, folded to the first quadrant
	// ---------------------------------------------------------------
	logic [STB-1:0] sin_k;
	logic [15:0]    sin_r;
	logic [16:0]    sin_f;

	assign sin_k = tone_q[PB-1 -: STB];
	assign sin_r = 16'(sin_k[STB-3:0]) << (17 - STB);
	assign sin_f = sin_k[STB-2] ? (ssg_pkg::Q15_ONE - 17'(sin_r)) : 17'(sin_r);

	// ---------------------------------------------------------------
	// fade gain numerator and denominator for the current index
	// ---------------------------------------------------------------
	logic       in_fade_in;
	logic       in_fade_out;
	logic [32:0] idx_next;

	assign idx_next    = 33'(idx_q) + 33'd1;
	assign in_fade_in  = (fade_q != '0) && (33'(idx_q) < 33'(fade_q));
	assign in_fade_out = (fade_q != '0) && (33'(idx_q) + 33'(fade_q) >= 33'(len_q));

	// ---------------------------------------------------------------
	// phase sums and final scaling
	// ---------------------------------------------------------------
	logic [48:0] step_sum;
	logic [63:0] tone_sum;
	logic [63:0] lfo_sum;
	logic [63:0] scale_sum;
	logic [47:0] amp_prod;

	assign step_sum = 49'(low_prod_q) + 49'(prod[47:0]);
	assign tone_sum = 64'(tone_q) + 64'(step_sum[48:16]);
	assign lfo_sum  = 64'(lfo_q)
		+ 64'(mode_q ? regs.yelp_lfo_step : regs.wail_lfo_step);

	// times 32767 as shift and subtract, plus half of den*2^30 for rounding
	assign amp_prod  = prod[47:0];
	assign scale_sum = (64'(amp_prod) << 15) - 64'(amp_prod) + (64'(den_q) << 29);

	logic last_c;
	logic load_out;

	assign last_c   = idx_next >= 33'(len_q);
	assign load_out = (state_q == ssg_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// ---------------------------------------------------------------
	// sequencer: next state, multiplier operands, divider start
	// ---------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			ssg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = opens ? ssg_pkg::ST_LO : ssg_pkg::ST_DONE;
			end
			ssg_pkg::ST_LO: begin
				// low step weighted by one minus the triangle
				mul_a   = ssg_pkg::MUL_A_W'(regs.low_freq_step);
				mul_b   = ssg_pkg::Q16_ONE - tri_u;
				state_d = ssg_pkg::ST_HI;
			end
			ssg_pkg::ST_HI: begin
				mul_a   = ssg_pkg::MUL_A_W'(regs.high_freq_step);
				mul_b   = tri_u;
				state_d = ssg_pkg::ST_PHASE;
			end
			ssg_pkg::ST_PHASE: begin
				state_d = ssg_pkg::ST_SQ;
			end
			ssg_pkg::ST_SQ: begin
				mul_a   = ssg_pkg::MUL_A_W'(sin_f);
				mul_b   = sin_f;
				state_d = ssg_pkg::ST_T;
			end
			ssg_pkg::ST_T: begin
				mul_a   = ssg_pkg::MUL_A_W'(ssg_pkg::SIN_C);
				mul_b   = prod[31:15];
				state_d = ssg_pkg::ST_T2;
			end
			ssg_pkg::ST_T2: begin
				mul_a   = ssg_pkg::MUL_A_W'(x2_q);
				mul_b   = ssg_pkg::SIN_B - prod[31:15];
				state_d = ssg_pkg::ST_MAG;
			end
			ssg_pkg::ST_MAG: begin
				mul_a   = ssg_pkg::MUL_A_W'(sin_f);
				mul_b   = ssg_pkg::SIN_A - prod[31:15];
				state_d = ssg_pkg::ST_NUM;
			end
			ssg_pkg::ST_NUM: begin
				// sine magnitude times fade numerator
				mul_a   = ssg_pkg::MUL_A_W'(prod[32:15]);
				mul_b   = ssg_pkg::MUL_B_W'(num_q);
				state_d = ssg_pkg::ST_AMP;
			end
			ssg_pkg::ST_AMP: begin
				mul_a   = prod[ssg_pkg::MUL_A_W-1:0];
				mul_b   = ssg_pkg::MUL_B_W'(regs.amplitude);
				state_d = ssg_pkg::ST_SCALE;
			end
			ssg_pkg::ST_SCALE: begin
				state_d = ssg_pkg::ST_DIVGO;
			end
			ssg_pkg::ST_DIVGO: begin
				div_start = 1'b1;
				state_d   = ssg_pkg::ST_DIV;
			end
			ssg_pkg::ST_DIV: begin
				if (div_res.done)
					state_d = ssg_pkg::ST_DONE;
			end
			ssg_pkg::ST_DONE: begin
				if (load_out)
					state_d = ssg_pkg::ST_IDLE;
			end
			default: begin
				state_d = ssg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ssg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------------------------------------------------------
	// block state, phases and output valid
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q      <= '0;
			lfo_q       <= '0;
			idx_q       <= '0;
			len_q       <= '0;
			fade_q      <= '0;
			mode_q      <= 1'b0;
			open_q      <= 1'b0;
			silent_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				silent_q <= !opens;
				if (start_block) begin
					if (frames == '0) begin
						open_q <= 1'b0;
					end else begin
						len_q  <= frames;
						mode_q <= mode;
						tone_q <= '0;
						lfo_q  <= '0;
						idx_q  <= '0;
						fade_q <= fade_start;
						open_q <= 1'b1;
					end
				end
			end

			if (state_q == ssg_pkg::ST_PHASE)
				tone_q <= tone_sum[PB-1:0];

			if (load_out) begin
				out_valid_q <= 1'b1;
				if (!silent_q) begin
					lfo_q <= lfo_sum[PB-1:0];
					idx_q <= idx_next[FCB-1:0];
					if (last_c)
						open_q <= 1'b0;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// working registers and output beat
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == ssg_pkg::ST_LO) begin
			if (in_fade_in) begin
				num_q <= ssg_pkg::FADE_W'(idx_next);
				den_q <= fade_q;
			end else if (in_fade_out) begin
				num_q <= ssg_pkg::FADE_W'(33'(len_q) - 33'(idx_q));
				den_q <= fade_q;
			end else begin
				num_q <= ssg_pkg::FADE_W'(1);
				den_q <= ssg_pkg::FADE_W'(1);
			end
		end
		if (state_q == ssg_pkg::ST_HI)
			low_prod_q <= prod[47:0];
		if (state_q == ssg_pkg::ST_T)
			x2_q <= prod[31:15];
		if (state_q == ssg_pkg::ST_SQ)
			neg_q <= sin_k[STB-1];
		if (state_q == ssg_pkg::ST_SCALE)
			scaled_q <= scale_sum[63:30];
		if (state_q == ssg_pkg::ST_DIV && div_res.done)
			res_q <= neg_q ? (16'd0 - 16'(div_res.quot)) : 16'(div_res.quot);
		if (load_out) begin
			sample_q <= silent_q ? 16'd0 : res_q;
			last_q   <= !silent_q && last_c;
			active_q <= !silent_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample        = sample_q;
	assign last_in_block = last_q;
	assign active        = active_q;

endmodule
